### rtl/core/cmsg_pkg.sv
// ----------------------------------------------------------------------------
// cmsg_pkg
// shared types, constants and helpers of the cylinder mesh segment generator
// ----------------------------------------------------------------------------
package cmsg_pkg;

    localparam int MAX_SEGMENTS   = 1024;
    localparam int COORD_WIDTH    = 16;
    localparam int CORDIC_STAGES  = 16;
    localparam int CYCLES_PER_ITEM = 16;

    localparam int XY_W   = 33;
    localparam int Z_W    = 25;
    localparam int PROD_W = XY_W + 16;
    localparam int OFS_W  = 18;
    localparam int SUM_W  = 20;
    localparam int SEG_W  = 10;
    localparam int M_W    = 10;
    localparam int STEP_W = 4;

    localparam logic signed [XY_W-1:0] INV_GAIN = 33'sd652032874;

    typedef enum logic [2:0] {
        REG_SEGMENTS   = 3'd0,
        REG_ANGLE_STEP = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_HEIGHT     = 3'd3,
        REG_CENTER_X   = 3'd4,
        REG_CENTER_Y   = 3'd5,
        REG_CENTER_Z   = 3'd6
    } reg_index_t;

    typedef enum logic {
        KIND_VERTEX = 1'b0,
        KIND_INDEX  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                   valid;
        logic [SEG_W-1:0]       idx;
        logic [M_W-1:0]         m;
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] k);
        logic signed [Z_W-1:0] r;
        case (k)
            5'd0:  r = 25'sd2097152;
            5'd1:  r = 25'sd1238021;
            5'd2:  r = 25'sd654136;
            5'd3:  r = 25'sd332050;
            5'd4:  r = 25'sd166669;
            5'd5:  r = 25'sd83416;
            5'd6:  r = 25'sd41718;
            5'd7:  r = 25'sd20860;
            5'd8:  r = 25'sd10430;
            5'd9:  r = 25'sd5215;
            5'd10: r = 25'sd2608;
            5'd11: r = 25'sd1304;
            5'd12: r = 25'sd652;
            5'd13: r = 25'sd326;
            5'd14: r = 25'sd163;
            5'd15: r = 25'sd81;
            5'd16: r = 25'sd41;
            5'd17: r = 25'sd20;
            5'd18: r = 25'sd10;
            5'd19: r = 25'sd5;
            5'd20: r = 25'sd3;
            5'd21: r = 25'sd1;
            5'd22: r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [COORD_WIDTH-1:0] r;
        hi = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            r = hi[COORD_WIDTH-1:0];
        else if (v < lo)
            r = lo[COORD_WIDTH-1:0];
        else
            r = v[COORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

### rtl/core/cmsg_cordic_cell.sv
// ----------------------------------------------------------------------------
// cmsg_cordic_cell
// one rotation step of the sine and cosine chain, registered
// ----------------------------------------------------------------------------
module cmsg_cordic_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        k,
    input  cmsg_pkg::cordic_t din,
    output cmsg_pkg::cordic_t dout
);

    cmsg_pkg::cordic_t stage_reg;
    cmsg_pkg::cordic_t stage_next;
    logic signed [cmsg_pkg::XY_W-1:0] dx;
    logic signed [cmsg_pkg::XY_W-1:0] dy;
    logic signed [cmsg_pkg::Z_W-1:0]  da;

    always_comb
    begin
        dx = din.y >>> k;
        dy = din.x >>> k;
        da = cmsg_pkg::atan_val(k);
        stage_next = din;
        if (!din.z[cmsg_pkg::Z_W-1])
        begin
            stage_next.x = din.x - dx;
            stage_next.y = din.y + dy;
            stage_next.z = din.z - da;
        end
        else
        begin
            stage_next.x = din.x + dx;
            stage_next.y = din.y - dy;
            stage_next.z = din.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

### rtl/core/cmsg_emitter.sv
// ----------------------------------------------------------------------------
// cmsg_emitter
// scales sine and cosine by the radius and steps out the segment's records
// ----------------------------------------------------------------------------
module cmsg_emitter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmsg_pkg::cordic_t        din,
    input  logic [14:0]              radius,
    input  logic [14:0]              height,
    input  logic signed [15:0]       center_x,
    input  logic signed [15:0]       center_y,
    input  logic signed [15:0]       center_z,
    output logic                     result_valid,
    output logic                     kind,
    output logic [13:0]              slot,
    output logic signed [15:0]       pos_x,
    output logic signed [15:0]       pos_y,
    output logic signed [15:0]       pos_z,
    output logic signed [15:0]       norm_x,
    output logic signed [15:0]       norm_y,
    output logic signed [15:0]       norm_z,
    output logic [10:0]              index_value,
    output logic                     last
);

    localparam int PW = cmsg_pkg::PROD_W;
    localparam int SW = cmsg_pkg::SUM_W;

    logic                          active_reg, active_next;
    logic [cmsg_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [cmsg_pkg::SEG_W-1:0]    idx_reg;
    logic [cmsg_pkg::M_W-1:0]      m_reg;
    logic signed [PW-1:0]          prod_s_reg;
    logic signed [PW-1:0]          prod_c_reg;

    logic signed [cmsg_pkg::XY_W-1:0] s_sel, c_sel;
    logic signed [PW-1:0] rnd_s, rnd_c;
    logic signed [cmsg_pkg::OFS_W-1:0] ox, oz;
    logic signed [SW-1:0] h, cx, cy, cz;
    logic rim_last;
    logic [10:0] i11, m11, j11, mi11, mj11;
    logic [13:0] i14, m14, t14;
    logic [3:0] t;

    always_comb
    begin
        case (din.quad)
            2'd0:    begin c_sel = din.x;  s_sel = din.y;  end
            2'd1:    begin c_sel = -din.y; s_sel = din.x;  end
            2'd2:    begin c_sel = -din.x; s_sel = -din.y; end
            default: begin c_sel = din.y;  s_sel = -din.x; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (din.valid)
        begin
            idx_reg    <= din.idx;
            m_reg      <= din.m;
            prod_s_reg <= PW'(s_sel) * $signed({1'b0, radius});
            prod_c_reg <= PW'(c_sel) * $signed({1'b0, radius});
        end
    end

    assign rim_last = (idx_reg == m_reg - cmsg_pkg::M_W'(1));

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (din.valid)
        begin
            active_next = 1'b1;
            step_next   = '0;
        end
        else if (active_reg)
        begin
            if (step_reg == 4'd15)
                active_next = 1'b0;
            else if (step_reg == 4'd1 && !rim_last)
                step_next = 4'd4;
            else
                step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_comb
    begin
        rnd_s = prod_s_reg + (PW'(1) <<< 29);
        rnd_c = prod_c_reg + (PW'(1) <<< 29);
        ox = rnd_s[30 +: cmsg_pkg::OFS_W];
        oz = rnd_c[30 +: cmsg_pkg::OFS_W];
        h  = SW'({1'b0, height[14:1]});
        cx = SW'(center_x);
        cy = SW'(center_y);
        cz = SW'(center_z);
        i11  = 11'(idx_reg);
        m11  = 11'(m_reg);
        j11  = rim_last ? 11'd0 : i11 + 11'd1;
        mi11 = m11 + i11;
        mj11 = m11 + j11;
        i14  = 14'(idx_reg);
        m14  = 14'(m_reg);
        t    = step_reg - 4'd4;
        t14  = 14'(t);

        kind        = cmsg_pkg::KIND_VERTEX;
        slot        = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        norm_x      = '0;
        norm_y      = '0;
        norm_z      = '0;
        index_value = '0;
        last        = active_reg && (step_reg == 4'd15);

        case (step_reg) inside
            4'd0, 4'd1:
            begin
                slot   = (step_reg == 4'd0) ? i14 : m14 + i14;
                pos_x  = cmsg_pkg::sat_coord(cx + SW'(ox));
                pos_z  = cmsg_pkg::sat_coord(cz + SW'(oz));
                norm_x = cmsg_pkg::sat_coord(SW'(ox));
                norm_z = cmsg_pkg::sat_coord(SW'(oz));
                pos_y  = cmsg_pkg::sat_coord((step_reg == 4'd0) ? cy + h : cy - h);
                norm_y = cmsg_pkg::sat_coord((step_reg == 4'd0) ? h : -h);
            end
            4'd2, 4'd3:
            begin
                slot   = (step_reg == 4'd2) ? {m14[12:0], 1'b0}
                                            : {m14[12:0], 1'b1};
                pos_x  = cmsg_pkg::sat_coord(cx);
                pos_z  = cmsg_pkg::sat_coord(cz);
                pos_y  = cmsg_pkg::sat_coord((step_reg == 4'd2) ? cy + h : cy - h);
                norm_y = cmsg_pkg::sat_coord((step_reg == 4'd2) ? h : -h);
            end
            default:
            begin
                kind = cmsg_pkg::KIND_INDEX;
                if (t < 4'd9)
                    slot = 14'(i14 * 14'd9) + t14;
                else
                    slot = 14'(m14 * 14'd9) + 14'(i14 * 14'd3) + (t14 - 14'd9);
                case (t) inside
                    4'd0, 4'd3, 4'd6:  index_value = j11;
                    4'd1:              index_value = {m11[9:0], 1'b0};
                    4'd2, 4'd4:        index_value = i11;
                    4'd5, 4'd7, 4'd11: index_value = mi11;
                    4'd8, 4'd9:        index_value = mj11;
                    4'd10:             index_value = {m11[9:0], 1'b1};
                    default:           index_value = '0;
                endcase
            end
        endcase
    end

    assign result_valid = active_reg;

endmodule

### rtl/core/cylinder_mesh_segment_generator.sv
// ----------------------------------------------------------------------------
// cylinder_mesh_segment_generator
// emits the vertex and index records of one rim point of a capped cylinder
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low; busy then stays high
// while the gap counter counts down, which spaces segments to suit the single
// result port that carries up to 16 records per segment. Results pass the phase
// multiply, 16 rotation cells and the radius multiply and stream out one per
// cycle under result_valid, 14 records or 16 for the last rim point, while the
// next segment already moves down the rotation chain. The receiver cannot stall
// the results. Configuration writes are always taken and belong in idle time only.
module cylinder_mesh_segment_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         segment,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic               kind,
    output logic [13:0]        slot,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [10:0]        index_value,
    output logic               last
);

    localparam int NS = (cmsg_pkg::CORDIC_STAGES < 24) ? cmsg_pkg::CORDIC_STAGES : 24;

    logic [10:0]        segments_reg;
    logic [15:0]        angle_step_reg;
    logic [14:0]        radius_reg;
    logic [14:0]        height_reg;
    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;
    logic signed [15:0] center_z_reg;

    logic [3:0] gap_reg, gap_next;
    logic       accept;
    logic [10:0] n_clamp;
    logic [cmsg_pkg::M_W-1:0] m_val;
    logic       item_ok;

    logic                     prep_valid_reg;
    logic [9:0]               prep_idx_reg;
    logic [cmsg_pkg::M_W-1:0] prep_m_reg;
    logic [15:0]              prep_phase_reg;
    logic [25:0]              phase_full;

    cmsg_pkg::cordic_t chain [0:NS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg   <= 11'd50;
            angle_step_reg <= 16'd1337;
            radius_reg     <= 15'd205;
            height_reg     <= 15'd2048;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmsg_pkg::REG_SEGMENTS:   segments_reg   <= cfg_data[10:0];
                cmsg_pkg::REG_ANGLE_STEP: angle_step_reg <= cfg_data;
                cmsg_pkg::REG_RADIUS:     radius_reg     <= cfg_data[14:0];
                cmsg_pkg::REG_HEIGHT:     height_reg     <= cfg_data[14:0];
                cmsg_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data;
                cmsg_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data;
                cmsg_pkg::REG_CENTER_Z:   center_z_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy   = (gap_reg != '0);
    assign accept = start && !busy;

    always_comb
    begin
        gap_next = gap_reg;
        if (accept)
            gap_next = 4'(cmsg_pkg::CYCLES_PER_ITEM - 1);
        else if (gap_reg != '0)
            gap_next = gap_reg - 4'd1;
    end

    always_comb
    begin
        n_clamp = (segments_reg > 11'(cmsg_pkg::MAX_SEGMENTS))
                ? 11'(cmsg_pkg::MAX_SEGMENTS) : segments_reg;
        m_val   = cmsg_pkg::M_W'(n_clamp - 11'd1);
        item_ok = (n_clamp >= 11'd2) && (11'(segment) < n_clamp - 11'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg        <= '0;
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            gap_reg        <= gap_next;
            prep_valid_reg <= accept && item_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prep_idx_reg   <= segment;
            prep_m_reg     <= m_val;
            prep_phase_reg <= phase_full[15:0];
        end
    end

    assign phase_full = segment * angle_step_reg;

    always_comb
    begin
        chain[0].valid = prep_valid_reg;
        chain[0].idx   = prep_idx_reg;
        chain[0].m     = prep_m_reg;
        chain[0].quad  = prep_phase_reg[15:14];
        chain[0].x     = cmsg_pkg::INV_GAIN;
        chain[0].y     = '0;
        chain[0].z     = cmsg_pkg::Z_W'({prep_phase_reg[13:0], 8'd0});
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_cell
            cmsg_cordic_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .k     (5'(g)),
                .din   (chain[g]),
                .dout  (chain[g+1])
            );
        end
    endgenerate

    cmsg_emitter u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .din          (chain[NS]),
        .radius       (radius_reg),
        .height       (height_reg),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .center_z     (center_z_reg),
        .result_valid (result_valid),
        .kind         (kind),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .index_value  (index_value),
        .last         (last)
    );

endmodule

### tb/tb_cylinder_mesh_segment_generator.sv
// ----------------------------------------------------------------------------
// tb_cylinder_mesh_segment_generator
// drives rim point numbers into the segment generator under several register
// settings, predicts each vertex and index record with a cordic model of its
// own and compares every result strobe with the oldest predicted record
// ----------------------------------------------------------------------------
module tb_cylinder_mesh_segment_generator;

    typedef struct packed {
        logic        kind;
        logic [13:0] slot;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [10:0] idx;
        logic        last;
    } mesh_rec_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [9:0]  segment;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic        kind;
    logic [13:0] slot;
    logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
    logic [10:0] index_value;
    logic        last;

    cylinder_mesh_segment_generator dut (.*);

    // predictor registers
    logic [10:0] n_segs;
    logic [15:0] step_reg;
    logic [14:0] radius_reg;
    logic [14:0] height_reg;
    logic signed [15:0] cx_reg, cy_reg, cz_reg;

    mesh_rec_t expected_recs[$];
    logic [9:0] segment_queue[$];
    int   wait_queue[$];
    int   gap_left;
    int   mismatches;
    bit   cfg_busy;

    localparam longint ATAN_TAB[24] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic void add_expected(mesh_rec_t r);
        expected_recs = {expected_recs, r};
    endfunction

    function automatic mesh_rec_t vertex_rec(int s, longint x, longint y, longint z,
                                             longint a, longint b, longint c);
        mesh_rec_t r;
        r = '0;
        r.kind = cmsg_pkg::KIND_VERTEX;
        r.slot = s[13:0];
        r.px = clamp16(x);
        r.py = clamp16(y);
        r.pz = clamp16(z);
        r.nx = clamp16(a);
        r.ny = clamp16(b);
        r.nz = clamp16(c);
        return r;
    endfunction

    task automatic predict_segment(input logic [9:0] seg);
        int m, i, j, n;
        longint x, y, z, dx, dy, sn, cs, ox, oz, h, rad;
        logic [15:0] phase;
        int vals[12];
        mesh_rec_t r;
        n = n_segs;
        if (n > cmsg_pkg::MAX_SEGMENTS)
            n = cmsg_pkg::MAX_SEGMENTS;
        if (n < 2)
            return;
        m = n - 1;
        i = seg;
        if (i >= m)
            return;
        j = (i == m - 1) ? 0 : i + 1;
        phase = 16'(i * step_reg);
        x = 652032874;
        y = 0;
        z = longint'(phase[13:0]) << 8;
        for (int k = 0; k < cmsg_pkg::CORDIC_STAGES; k++)
        begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TAB[k];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TAB[k];
            end
        end
        case (phase[15:14])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        rad = longint'(radius_reg);
        ox = floor_shift(sn * rad + (64'sd1 << 29), 30);
        oz = floor_shift(cs * rad + (64'sd1 << 29), 30);
        h = height_reg >> 1;
        add_expected(vertex_rec(i, cx_reg + ox, cy_reg + h, cz_reg + oz, ox, h, oz));
        add_expected(vertex_rec(m + i, cx_reg + ox, cy_reg - h, cz_reg + oz,
                                ox, -h, oz));
        if (i == m - 1)
        begin
            add_expected(vertex_rec(2 * m, cx_reg, cy_reg + h, cz_reg, 0, h, 0));
            add_expected(vertex_rec(2 * m + 1, cx_reg, cy_reg - h, cz_reg, 0, -h, 0));
        end
        vals = '{j, 2 * m, i, j, i, m + i, j, m + i, m + j, m + j, 2 * m + 1, m + i};
        for (int t = 0; t < 12; t++)
        begin
            r = '0;
            r.kind = cmsg_pkg::KIND_INDEX;
            r.slot = 14'((t < 9) ? 9 * i + t : 9 * m + 3 * i + t - 9);
            r.idx = 11'(vals[t]);
            r.last = (t == 11);
            add_expected(r);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            segment <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            predict_segment(segment);
            start <= 1'b0;
            gap_left <= wait_queue.size() ? wait_queue[0] : 0;
        end
        else if (!start && !cfg_busy && segment_queue.size() > 0)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else
            begin
                segment <= segment_queue.pop_front();
                void'(wait_queue.pop_front());
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            mesh_rec_t got, exp_rec;
            got = {kind, slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, index_value, last};
            if (expected_recs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                exp_rec = expected_recs.pop_front();
                if (got !== exp_rec)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_rec, got);
                end
            end
        end
    end

    task automatic queue_segment(input int seg);
        segment_queue = {segment_queue, 10'(seg)};
        wait_queue = {wait_queue,
                      (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17)))};
    endtask

    task automatic drain;
        while (segment_queue.size() > 0 || start)
            @(negedge clk);
        while (expected_recs.size() > 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cmsg_pkg::reg_index_t ri, input logic [15:0] v);
        cfg_busy = 1'b1;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (ri)
            cmsg_pkg::REG_SEGMENTS:   n_segs = v[10:0];
            cmsg_pkg::REG_ANGLE_STEP: step_reg = v;
            cmsg_pkg::REG_RADIUS:     radius_reg = v[14:0];
            cmsg_pkg::REG_HEIGHT:     height_reg = v[14:0];
            cmsg_pkg::REG_CENTER_X:   cx_reg = v;
            cmsg_pkg::REG_CENTER_Y:   cy_reg = v;
            default:                  cz_reg = v;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_busy = 1'b0;
    endtask

    task automatic random_phase(input int count);
        int m;
        m = (n_segs > cmsg_pkg::MAX_SEGMENTS ? cmsg_pkg::MAX_SEGMENTS : n_segs) - 1;
        for (int k = 0; k < count; k++)
        begin
            if (m >= 1 && $urandom_range(0, 9) != 0)
                queue_segment((m > 1023 ? $urandom_range(0, 1022) : $urandom_range(0, m - 1)));
            else
                queue_segment($urandom_range(0, 1023));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_busy = 1'b1;
        mismatches = 0;
        n_segs = 50; step_reg = 1337; radius_reg = 205; height_reg = 2048;
        cx_reg = 0; cy_reg = 0; cz_reg = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_busy = 1'b0;

        // directed: reset setting, ends of the ring, out of range
        queue_segment(0); queue_segment(48); queue_segment(1); queue_segment(49);
        queue_segment(1023); queue_segment(24);
        drain();

        // extremes of every register
        write_reg(cmsg_pkg::REG_SEGMENTS, 16'd1024);
        write_reg(cmsg_pkg::REG_ANGLE_STEP, 16'd32768);
        write_reg(cmsg_pkg::REG_RADIUS, 16'd32767);
        write_reg(cmsg_pkg::REG_HEIGHT, 16'd32767);
        write_reg(cmsg_pkg::REG_CENTER_X, 16'h7fff);
        write_reg(cmsg_pkg::REG_CENTER_Y, 16'h8000);
        write_reg(cmsg_pkg::REG_CENTER_Z, 16'h7fff);
        queue_segment(0); queue_segment(1); queue_segment(1022); queue_segment(1023);
        queue_segment(511); queue_segment(682);
        drain();
        write_reg(cmsg_pkg::REG_SEGMENTS, 16'd2047);
        write_reg(cmsg_pkg::REG_ANGLE_STEP, 16'd1);
        write_reg(cmsg_pkg::REG_CENTER_X, 16'h8000);
        write_reg(cmsg_pkg::REG_CENTER_Y, 16'h7fff);
        write_reg(cmsg_pkg::REG_CENTER_Z, 16'h8000);
        queue_segment(1022); queue_segment(341); queue_segment(1023);
        drain();
        write_reg(cmsg_pkg::REG_SEGMENTS, 16'd1);
        queue_segment(0); queue_segment(5);
        drain();
        write_reg(cmsg_pkg::REG_SEGMENTS, 16'd3);
        write_reg(cmsg_pkg::REG_ANGLE_STEP, 16'd32768);
        write_reg(cmsg_pkg::REG_RADIUS, 16'd0);
        write_reg(cmsg_pkg::REG_HEIGHT, 16'd0);
        queue_segment(0); queue_segment(1); queue_segment(2);
        drain();

        // random settings
        for (int p = 0; p < 6; p++)
        begin
            write_reg(cmsg_pkg::REG_SEGMENTS, 16'($urandom_range(3, (p % 2) ? 1024 : 64)));
            write_reg(cmsg_pkg::REG_ANGLE_STEP,
                      16'(65536 / (n_segs - 1) + $urandom_range(0, 1)));
            write_reg(cmsg_pkg::REG_RADIUS, 16'($urandom_range(0, 32767)));
            write_reg(cmsg_pkg::REG_HEIGHT, 16'($urandom_range(0, 32767)));
            write_reg(cmsg_pkg::REG_CENTER_X, 16'($urandom()));
            write_reg(cmsg_pkg::REG_CENTER_Y, 16'($urandom()));
            write_reg(cmsg_pkg::REG_CENTER_Z, 16'($urandom()));
            random_phase(35);
        end

        if (mismatches == 0 && expected_recs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
